>>> rtl/qpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qpc_pkg: shared definitions for the quadrature position counter
// Field widths, reset values, action codes and the result record.
// ----------------------------------------------------------------------------
package qpc_pkg;

   localparam int SAMPLE_COUNT_DEFAULT = 10;
   localparam int SAMPLES_W            = 10;
   localparam int THRESHOLD_W          = 4;
   localparam int POSITION_W           = 32;
   localparam int ACTION_W             = 2;

   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 4'd5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_EDGE_A = 2'd0,
      ACT_EDGE_B = 2'd1,
      ACT_READ   = 2'd2,
      ACT_MARK   = 2'd3
   } action_type;

   typedef struct packed {
      logic                  level_b;
      logic                  level_a;
      logic                  changed;
      logic [POSITION_W-1:0] relative_position;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/qpc_majority_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qpc_majority_filter: majority vote over raw pin samples
// Counts the one samples and reports a high level when the count exceeds
// the programmed threshold.
// ----------------------------------------------------------------------------
module qpc_majority_filter #(
   parameter int SAMPLE_COUNT = qpc_pkg::SAMPLE_COUNT_DEFAULT
) (
   input  wire logic [qpc_pkg::SAMPLES_W-1:0]   samples,
   input  wire logic [qpc_pkg::THRESHOLD_W-1:0] threshold,
   output logic                                 level
);
   import qpc_pkg::*;

   // only the bits present in the field can be counted
   localparam int CountedBits = (SAMPLE_COUNT < SAMPLES_W) ? SAMPLE_COUNT : SAMPLES_W;
   localparam int CountW      = $clog2(CountedBits + 1);
   localparam int CmpW        = (CountW > THRESHOLD_W) ? CountW : THRESHOLD_W;

   logic [CountW-1:0] ones;
   logic [CmpW-1:0]   ones_ext;
   logic [CmpW-1:0]   threshold_ext;

   always_comb begin
      ones = '0;
      for (int i = 0; i < CountedBits; i++) begin
         ones = ones + CountW'(samples[i]);
      end
   end

   assign ones_ext      = CmpW'(ones);
   assign threshold_ext = CmpW'(threshold);
   assign level         = (ones_ext > threshold_ext);

endmodule

`default_nettype wire

>>> rtl/qpc_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qpc_tracker: position, reference, channel levels and changed flag
// Applies one action per step and forms the result for the output register.
// ----------------------------------------------------------------------------
module qpc_tracker (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire qpc_pkg::action_type action,
   input  wire logic                level,
   output qpc_pkg::result_type      result
);
   import qpc_pkg::*;

   logic [POSITION_W-1:0] position_ff, position_in;
   logic [POSITION_W-1:0] reference_ff, reference_in;
   logic                  level_a_ff, level_a_in;
   logic                  level_b_ff, level_b_in;
   logic                  changed_ff, changed_in;
   logic                  changed_out;

   always_comb begin
      position_in  = position_ff;
      reference_in = reference_ff;
      level_a_in   = level_a_ff;
      level_b_in   = level_b_ff;
      changed_in   = changed_ff;
      changed_out  = changed_ff;
      case (action)
         ACT_EDGE_A: begin
            level_a_in = level;
            if (level && !level_b_ff) begin
               position_in = position_ff - POSITION_W'(1);
               changed_in  = 1'b1;
            end
            changed_out = changed_in;
         end
         ACT_EDGE_B: begin
            level_b_in = level;
            if (level && !level_a_ff) begin
               position_in = position_ff + POSITION_W'(1);
               changed_in  = 1'b1;
            end
            changed_out = changed_in;
         end
         ACT_READ: begin
            // report the flag as it stood, then clear it
            changed_in = 1'b0;
         end
         ACT_MARK: begin
            reference_in = position_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         reference_ff <= '0;
         level_a_ff   <= 1'b0;
         level_b_ff   <= 1'b0;
         changed_ff   <= 1'b0;
      end else if (step) begin
         position_ff  <= position_in;
         reference_ff <= reference_in;
         level_a_ff   <= level_a_in;
         level_b_ff   <= level_b_in;
         changed_ff   <= changed_in;
      end
   end

   assign result.relative_position = position_in - reference_in;
   assign result.changed           = changed_out;
   assign result.level_a           = level_a_in;
   assign result.level_b           = level_b_in;

endmodule

`default_nettype wire

>>> rtl/quadrature_position_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_position_counter: rotary encoder counter with majority filter
//
//   channel  direction  handshake          payload
//   req      in         tvalid / tready    tuser action, tdata pin samples
//   rsp      out        tvalid / tready    tdata position, flags
//   csr      in         wr_en              wr_data majority threshold
//
// An accepted transaction is held in the input register, then the filter and
// tracker update the state and load the result register; one transaction is
// taken every cycle while the result register is not stalled.
// A stalled result holds the result register; the input register then holds
// its transaction and req_tready drops until the result is taken.
// Synchronous reset clears the state, the valid bits and sets threshold to 5.
// ----------------------------------------------------------------------------
module quadrature_position_counter #(
   parameter int SAMPLE_COUNT = qpc_pkg::SAMPLE_COUNT_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [15:0]                         req_tdata,   // pin_samples[9:0], zero pad
   input  wire logic [qpc_pkg::ACTION_W-1:0]        req_tuser,   // action[1:0]
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // relative_position[31:0], changed, level_a_out, level_b_out, zero pad
   output logic [39:0]                              rsp_tdata,
   input  wire logic                                csr_wr_en,
   input  wire logic [qpc_pkg::THRESHOLD_W-1:0]     csr_wr_data
);
   import qpc_pkg::*;

   logic                   in_valid_ff;
   action_type             in_action_ff;
   logic [SAMPLES_W-1:0]   in_samples_ff;
   logic                   out_valid_ff;
   result_type             out_result_ff;
   logic [THRESHOLD_W-1:0] threshold_ff;

   logic       advance;
   logic       level;
   result_type result;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   qpc_majority_filter #(
      .SAMPLE_COUNT(SAMPLE_COUNT)
   ) u_filter (
      .samples  (in_samples_ff),
      .threshold(threshold_ff),
      .level    (level)
   );

   qpc_tracker u_tracker (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .action(in_action_ff),
      .level (level),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
      end
      if (req_tready && req_tvalid) begin
         in_action_ff  <= action_type'(req_tuser);
         in_samples_ff <= req_tdata[SAMPLES_W-1:0];
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_result_ff.level_b, out_result_ff.level_a,
                        out_result_ff.changed, out_result_ff.relative_position};

`ifndef NO_ASSERTIONS
   // a transaction leaving the input register always lands in the result register
   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced transaction did not reach result register");

   // a blocked transaction stays in the input register unchanged
   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_samples_ff)
                                     && $stable(in_action_ff)))
      else $error("blocked input transaction was lost or altered");

   // an empty input register never refuses a transaction
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input refused while input register empty");

   // a threshold write takes effect on the next cycle
   a_threshold_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (threshold_ff == $past(csr_wr_data)))
      else $error("threshold write not applied");
`endif

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: quadrature position counter
// Drives encoder edge, read and mark transactions through the request stream.
// A scoreboard tracks the filtered levels, the position, the reference and the
// changed flag. Every response is compared with the oldest expected result.
// The majority threshold is swept over several values, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
   import qpc_pkg::*;

   class position_scoreboard;
      logic [POSITION_W-1:0]  position;
      logic [POSITION_W-1:0]  marked_position;
      logic                   level_a;
      logic                   level_b;
      logic                   changed;
      logic [THRESHOLD_W-1:0] threshold;
      result_type             expected_results[$];
      int                     mismatches;
      int                     checked;
      int                     counts;

      function new();
         position        = '0;
         marked_position = '0;
         level_a         = 1'b0;
         level_b         = 1'b0;
         changed         = 1'b0;
         threshold       = THRESHOLD_RESET;
         mismatches      = 0;
         checked         = 0;
         counts          = 0;
      endfunction

      function void set_threshold(logic [THRESHOLD_W-1:0] value);
         threshold = value;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // update the tracked state for one accepted request and queue its result
      function void note_request(action_type act, logic [SAMPLES_W-1:0] samples);
         result_type r;
         logic       lvl;
         lvl = ($countones(samples) > threshold);
         r.changed = changed;
         case (act)
            ACT_EDGE_A: begin
               level_a = lvl;
               if (level_a && !level_b) begin
                  position = position - 1;
                  changed  = 1'b1;
                  counts++;
               end
               r.changed = changed;
            end
            ACT_EDGE_B: begin
               level_b = lvl;
               if (level_b && !level_a) begin
                  position = position + 1;
                  changed  = 1'b1;
                  counts++;
               end
               r.changed = changed;
            end
            ACT_READ: begin
               // the response carries the flag as it was before the clear
               r.changed = changed;
               changed   = 1'b0;
            end
            default: begin
               marked_position = position;
               r.changed       = changed;
            end
         endcase
         r.relative_position = position - marked_position;
         r.level_a           = level_a;
         r.level_b           = level_b;
         expected_results.push_back(r);
      endfunction

      task report(string msg);
         if (mismatches < 20) $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_response(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            report("response with no request outstanding");
         end else begin
            want = expected_results.pop_front();
            checked++;
            if (got.relative_position !== want.relative_position)
               report($sformatf("relative_position got %0d expected %0d",
                                $signed(got.relative_position),
                                $signed(want.relative_position)));
            if (got.changed !== want.changed)
               report($sformatf("changed got %b expected %b", got.changed, want.changed));
            if (got.level_a !== want.level_a)
               report($sformatf("level_a got %b expected %b", got.level_a, want.level_a));
            if (got.level_b !== want.level_b)
               report($sformatf("level_b got %b expected %b", got.level_b, want.level_b));
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [15:0]            req_tdata = '0;    // pin_samples[9:0], zero pad
   logic [ACTION_W-1:0]    req_tuser = ACT_READ;  // action[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // relative_position[31:0], changed, level_a_out, level_b_out, zero pad
   logic [39:0]            rsp_tdata;
   logic                   csr_wr_en = 1'b0;
   logic [THRESHOLD_W-1:0] csr_wr_data = '0;

   position_scoreboard sb = new();
   bit                 idle_on = 1'b1;

   quadrature_position_counter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_item(input action_type act, input logic [SAMPLES_W-1:0] samples);
      if (idle_on && $urandom_range(4, 0) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, samples};
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      sb.note_request(act, samples);
   endtask

   task automatic write_threshold(input logic [THRESHOLD_W-1:0] value);
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_threshold(value);
   endtask

   // pin samples whose number of ones lands on the wanted side of the threshold, where the sample field allows it
   function automatic logic [SAMPLES_W-1:0] make_samples(bit want_high, int thr);
      int                   k;
      logic [SAMPLES_W-1:0] s;
      if (want_high) k = (thr >= SAMPLES_W) ? SAMPLES_W : $urandom_range(SAMPLES_W, thr + 1);
      else k = $urandom_range((thr > SAMPLES_W) ? SAMPLES_W : thr, 0);
      s = '0;
      while ($countones(s) < k) s[$urandom_range(SAMPLES_W - 1, 0)] = 1'b1;
      return s;
   endfunction

   // mostly gray-code rotation with occasional reversal, bounce, random edges, reads and marks
   task automatic rotate_items(input int n);
      logic [1:0] dir;
      logic [1:0] cur;
      logic [1:0] nxt;
      logic       a_new;
      logic       b_new;
      int         roll;
      dir = 2'd1;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(99, 0);
         if (roll < 8) begin
            send_item($urandom_range(1, 0) ? ACT_EDGE_B : ACT_EDGE_A, 10'($urandom));
         end else if (roll < 20) begin
            send_item(ACT_READ, 10'($urandom));
         end else if (roll < 25) begin
            send_item(ACT_MARK, 10'($urandom));
         end else if (roll < 32) begin
            // contact bounce: the same level again on one channel
            if ($urandom_range(1, 0))
               send_item(ACT_EDGE_A, make_samples(sb.level_a, sb.threshold));
            else
               send_item(ACT_EDGE_B, make_samples(sb.level_b, sb.threshold));
         end else begin
            if ($urandom_range(15, 0) == 0) dir = -dir;
            cur   = {sb.level_a, sb.level_a ^ sb.level_b};
            nxt   = cur + dir;
            a_new = nxt[1];
            b_new = nxt[1] ^ nxt[0];
            if (a_new != sb.level_a)
               send_item(ACT_EDGE_A, make_samples(a_new, sb.threshold));
            else
               send_item(ACT_EDGE_B, make_samples(b_new, sb.threshold));
         end
      end
   endtask

   initial begin
      int stall_cycles;
      stall_cycles = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_response(result_type'(rsp_tdata[34:0]));
         if (stall_cycles > 0) begin
            stall_cycles--;
            rsp_tready <= (stall_cycles == 0);
         end else if (idle_on && $urandom_range(5, 0) == 0) begin
            stall_cycles = $urandom_range(3, 1);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int phase_threshold[6];
      phase_threshold = '{0, 10, 1, 6, 0, 8};
      phase_threshold[4] = $urandom_range(10, 0);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset threshold
      send_item(ACT_EDGE_A, 10'h3FF);   // count down from zero wraps
      send_item(ACT_EDGE_A, 10'h3FF);   // level already high still counts
      send_item(ACT_READ,   10'h3FF);
      send_item(ACT_READ,   10'h000);
      send_item(ACT_MARK,   10'h2AA);
      send_item(ACT_EDGE_A, 10'h000);
      send_item(ACT_EDGE_B, 10'h3FF);
      send_item(ACT_EDGE_B, 10'h3FF);
      send_item(ACT_EDGE_A, 10'h3FF);   // both high, no count
      send_item(ACT_EDGE_B, 10'h03F);
      send_item(ACT_EDGE_B, 10'h01F);   // exactly at threshold filters low
      send_item(ACT_EDGE_A, 10'h155);
      send_item(ACT_EDGE_B, 10'h2AA);
      send_item(ACT_EDGE_A, 10'h3F0);
      send_item(ACT_READ,   10'h155);
      send_item(ACT_MARK,   10'h3FF);
      send_item(ACT_EDGE_A, 10'h000);
      send_item(ACT_EDGE_B, 10'h3E0);
      send_item(ACT_READ,   10'h000);

      rotate_items(78);
      for (int p = 0; p < 6; p++) begin
         req_tvalid <= 1'b0;
         write_threshold(phase_threshold[p][THRESHOLD_W-1:0]);
         // threshold 0 and 10 get full-swing edges as well
         if (p == 0) send_item(ACT_EDGE_B, 10'h001);
         if (p == 1) send_item(ACT_EDGE_A, 10'h3FF);
         if (p == 5) idle_on = 1'b0;
         rotate_items(78);
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      $display("summary: %0d transactions checked, %0d position counts, %0d mismatches",
               sb.checked, sb.counts, sb.mismatches);
      $display("summary: thresholds 5, 0, 10, 1, 6, %0d and 8 exercised", phase_threshold[4]);
      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

>>> sim.f
rtl/qpc_pkg.sv
rtl/qpc_majority_filter.sv
rtl/qpc_tracker.sv
rtl/quadrature_position_counter.sv
bench/testbench.sv
